// ----- rtl/core/dopc_pkg.sv -----
// Package: shared types, op codes and constants for the discrete output PWM core.
`default_nettype none
package dopc_pkg;
    localparam int CHANNELS = 4;
    localparam int CH_W = 2;
    localparam int LEN_W = 26;
    localparam int TICK_W = 32;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    typedef enum logic [3:0] {
        OP_PEND   = 4'd0,
        OP_APPLY  = 4'd1,
        OP_NORMAL = 4'd2,
        OP_FAST   = 4'd3,
        OP_FILL   = 4'd4,
        OP_PERIOD = 4'd5,
        OP_PWM_EN = 4'd6,
        OP_MODE   = 4'd7,
        OP_SAFE_A = 4'd8,
        OP_SAFE_V = 4'd9,
        OP_TICK   = 4'd10
    } op_t;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_FAST   = 2'd1;
    localparam logic [1:0] MODE_PWM    = 2'd2;
    localparam logic [1:0] MODE_OFF    = 2'd3;

    localparam logic [2:0] REG_MIN_PULSE  = 3'd0;
    localparam logic [2:0] REG_TICK       = 3'd1;
    localparam logic [2:0] REG_FILL_MIN   = 3'd2;
    localparam logic [2:0] REG_FILL_MAX   = 3'd3;
    localparam logic [2:0] REG_PERIOD_MIN = 3'd4;

    typedef struct packed {
        logic [3:0]  op;
        logic [1:0]  channel;
        logic [15:0] value;
    } in_word_t;

    typedef struct packed {
        logic       updated;
        logic [3:0] pins;
        logic       timer_running;
        logic [3:0] safe_allow_mask;
        logic [3:0] safe_value_mask;
    } out_word_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch input word
        logic exec;     // simple commands, tick, apply
        logic mul;      // total = period*1000 ; product stage
        logic div;      // reciprocal estimate of product/25600
        logic lens;     // write high/low lengths, refresh
        logic emit;     // drive result strobe
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_len; // fill or period command on a valid channel
    } stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/dopc_ctrl.sv -----
// Controller: sequences one word through latch, execute, length math and result.
`default_nettype none
module dopc_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire dopc_pkg::stat_t stat,
    output logic                 busy,
    output dopc_pkg::cmd_t       cmd
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_MUL1 = 7'b0000100,
        S_MUL2 = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_LENS = 7'b0100000,
        S_EMIT = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
            begin
                cmd.load = start;
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = stat.need_len ? S_MUL1 : S_EMIT;
            end
            S_MUL1:
            begin
                cmd.mul = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.mul = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div = 1'b1;
                state_next = S_LENS;
            end
            S_LENS:
            begin
                cmd.lens = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
endmodule
`default_nettype wire

// ----- rtl/core/dopc_dp.sv -----
// Datapath: channel state, config registers, length arithmetic and tick logic.
`default_nettype none
module dopc_dp (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire dopc_pkg::in_word_t  cmd_word,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    input  wire dopc_pkg::cmd_t      cmd,
    output dopc_pkg::stat_t          stat,
    output logic                     done,
    output dopc_pkg::out_word_t      result
);
    localparam int N = dopc_pkg::CHANNELS;
    localparam int LW = dopc_pkg::LEN_W;
    localparam int TW = dopc_pkg::TICK_W;
    localparam logic [LW-1:0] LEN_MAX_26 = dopc_pkg::LEN_MAX;

    logic [15:0] min_pulse_reg, tick_us_reg, period_min_reg;
    logic [14:0] fill_min_reg, fill_max_reg;

    dopc_pkg::in_word_t in_reg;

    logic [1:0]  mode_reg [N];
    logic [N-1:0] nval_reg, fval_reg, pflag_reg, pval_reg, pwm_en_reg;
    logic [N-1:0] safe_en_reg, safe_lv_reg, phase_hi_reg, pin_reg;
    logic [15:0] period_reg [N];
    logic [14:0] fill_reg [N];
    logic [LW-1:0] high_reg [N];
    logic [LW-1:0] low_reg [N];
    logic [TW-1:0] ticks_reg [N];
    logic timer_reg, upd_reg, done_reg;

    // length math pipeline
    logic [25:0] total_reg;   // period*1000 < 2^26
    logic [40:0] prod_reg;    // total*fill
    logic [32:0] q_est_reg;   // reciprocal estimate of prod/25600

    logic [1:0]  ch;
    logic        bitv, valid_ch;
    logic [15:0] fill_c, period_c;

    assign ch = in_reg.channel;
    assign bitv = (in_reg.value != 16'd0);
    assign valid_ch = ({30'd0, ch} < N);
    assign stat.need_len = valid_ch &&
        ((in_reg.op == dopc_pkg::OP_FILL) || (in_reg.op == dopc_pkg::OP_PERIOD));

    always_comb
    begin
        fill_c = in_reg.value;
        if (fill_c < {1'b0, fill_min_reg}) fill_c = {1'b0, fill_min_reg};
        if (fill_c > {1'b0, fill_max_reg}) fill_c = {1'b0, fill_max_reg};
        period_c = in_reg.value;
        if (period_c < period_min_reg) period_c = period_min_reg;
    end

    // divide by 25600 = 256*100: shift then divide by 100 via reciprocal
    logic [32:0] q256;
    logic [32:0] q100_est;
    logic [65:0] recip_p;
    logic [32:0] rem;
    logic [32:0] q100;
    logic [32:0] hi_sat;
    logic [LW:0] tot_ext;
    logic [LW:0] lo_full;
    logic [LW-1:0] hi_fin, lo_fin;

    assign q256 = prod_reg[40:8];
    // 2^32/100 rounded down = 42949672; estimate may be low by up to two
    assign recip_p = {33'd0, q256} * 66'd42949672;
    assign q100_est = recip_p[64:32];
    assign rem = q256 - 33'(q_est_reg * 33'd100);
    assign q100 = (rem >= 33'd200) ? q_est_reg + 33'd2 :
                  ((rem >= 33'd100) ? q_est_reg + 33'd1 : q_est_reg);

    always_comb
    begin
        hi_sat = (q100 > {7'd0, LEN_MAX_26}) ? {7'd0, LEN_MAX_26} : q100;
        hi_fin = hi_sat[LW-1:0];
        if (hi_fin < {10'd0, min_pulse_reg}) hi_fin = '0;
        tot_ext = {1'b0, total_reg};
        lo_full = (tot_ext > {1'b0, hi_fin}) ? tot_ext - {1'b0, hi_fin} : '0;
        lo_fin = lo_full[LW-1:0];
        if (lo_fin < {10'd0, min_pulse_reg}) lo_fin = '0;
    end

    // tick next values per channel
    logic [TW-1:0] t_add [N];
    logic [N-1:0]  act;
    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            act[i] = (mode_reg[i] == dopc_pkg::MODE_PWM) && pwm_en_reg[i] &&
                     (high_reg[i] != '0);
            t_add[i] = (ticks_reg[i] > ({TW{1'b1}} - {16'd0, tick_us_reg})) ?
                       {TW{1'b1}} : ticks_reg[i] + {16'd0, tick_us_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_pulse_reg  <= 16'd100;
            tick_us_reg    <= 16'd100;
            fill_min_reg   <= 15'd0;
            fill_max_reg   <= 15'd25600;
            period_min_reg <= 16'd1;
            nval_reg <= '0; fval_reg <= '0; pflag_reg <= '0; pval_reg <= '0;
            pwm_en_reg <= '0; safe_en_reg <= '0; safe_lv_reg <= '0;
            phase_hi_reg <= '1; pin_reg <= '0;
            timer_reg <= 1'b0;
            upd_reg <= 1'b0;
            done_reg <= 1'b0;
            for (int i = 0; i < N; i++)
            begin
                mode_reg[i] <= dopc_pkg::MODE_NORMAL;
                period_reg[i] <= 16'd1000;
                fill_reg[i] <= 15'd12800;
                high_reg[i] <= '0;
                low_reg[i] <= '0;
                ticks_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cfg_we)
            begin
                case (cfg_index)
                    dopc_pkg::REG_MIN_PULSE:  min_pulse_reg <= cfg_data;
                    dopc_pkg::REG_TICK:       tick_us_reg <= cfg_data;
                    dopc_pkg::REG_FILL_MIN:   fill_min_reg <= cfg_data[14:0];
                    dopc_pkg::REG_FILL_MAX:   fill_max_reg <= cfg_data[14:0];
                    dopc_pkg::REG_PERIOD_MIN: period_min_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.exec)
            begin
                upd_reg <= 1'b0;
                if (in_reg.op == dopc_pkg::OP_TICK)
                begin
                    if (timer_reg)
                    begin
                        upd_reg <= 1'b1;
                        if (act == '0) timer_reg <= 1'b0;
                        for (int i = 0; i < N; i++)
                        begin
                            if (mode_reg[i] == dopc_pkg::MODE_PWM)
                            begin
                                pin_reg[i] <= 1'b0;
                                if (act[i])
                                begin
                                    ticks_reg[i] <= t_add[i];
                                    if (phase_hi_reg[i])
                                    begin
                                        if ((t_add[i] >= {6'd0, high_reg[i]}) &&
                                            (low_reg[i] != '0))
                                        begin
                                            phase_hi_reg[i] <= 1'b0;
                                            ticks_reg[i] <= '0;
                                        end
                                        else
                                        begin
                                            pin_reg[i] <= 1'b1;
                                        end
                                    end
                                    else if (t_add[i] >= {6'd0, low_reg[i]})
                                    begin
                                        phase_hi_reg[i] <= 1'b1;
                                        ticks_reg[i] <= '0;
                                    end
                                end
                            end
                        end
                    end
                end
                else if (in_reg.op == dopc_pkg::OP_APPLY)
                begin
                    if (bitv)
                    begin
                        upd_reg <= 1'b1;
                        for (int i = 0; i < N; i++)
                        begin
                            if ((mode_reg[i] == dopc_pkg::MODE_NORMAL) && pflag_reg[i] &&
                                (pval_reg[i] != nval_reg[i]))
                            begin
                                nval_reg[i] <= pval_reg[i];
                                pin_reg[i] <= pval_reg[i];
                                pflag_reg[i] <= 1'b0;
                            end
                        end
                    end
                end
                else if (valid_ch)
                begin
                    case (in_reg.op)
                        dopc_pkg::OP_PEND:
                        begin
                            pval_reg[ch] <= bitv;
                            pflag_reg[ch] <= 1'b1;
                            upd_reg <= 1'b1;
                        end
                        dopc_pkg::OP_NORMAL:
                        begin
                            nval_reg[ch] <= bitv;
                            if (mode_reg[ch] == dopc_pkg::MODE_NORMAL)
                            begin
                                pin_reg[ch] <= bitv;
                                upd_reg <= 1'b1;
                            end
                        end
                        dopc_pkg::OP_FAST:
                        begin
                            fval_reg[ch] <= bitv;
                            if (mode_reg[ch] == dopc_pkg::MODE_FAST)
                            begin
                                pin_reg[ch] <= bitv;
                                upd_reg <= 1'b1;
                            end
                        end
                        dopc_pkg::OP_FILL:
                        begin
                            fill_reg[ch] <= fill_c[14:0];
                            upd_reg <= 1'b1;
                        end
                        dopc_pkg::OP_PERIOD:
                        begin
                            period_reg[ch] <= period_c;
                            upd_reg <= 1'b1;
                        end
                        dopc_pkg::OP_PWM_EN:
                        begin
                            pwm_en_reg[ch] <= bitv;
                            upd_reg <= 1'b1;
                            if ((mode_reg[ch] == dopc_pkg::MODE_PWM) && bitv &&
                                (high_reg[ch] != '0)) timer_reg <= 1'b1;
                        end
                        dopc_pkg::OP_MODE:
                        begin
                            if ((in_reg.value <= 16'd3) &&
                                (in_reg.value[1:0] != mode_reg[ch]))
                            begin
                                upd_reg <= 1'b1;
                                mode_reg[ch] <= in_reg.value[1:0];
                                case (in_reg.value[1:0])
                                    dopc_pkg::MODE_NORMAL: pin_reg[ch] <= nval_reg[ch];
                                    dopc_pkg::MODE_FAST:   pin_reg[ch] <= fval_reg[ch];
                                    dopc_pkg::MODE_PWM:
                                    begin
                                        pin_reg[ch] <= 1'b0;
                                        if (pwm_en_reg[ch] && (high_reg[ch] != '0))
                                            timer_reg <= 1'b1;
                                    end
                                    default: pin_reg[ch] <= 1'b0;
                                endcase
                            end
                        end
                        dopc_pkg::OP_SAFE_A:
                        begin
                            if (safe_en_reg[ch] != bitv)
                            begin
                                safe_en_reg[ch] <= bitv;
                                upd_reg <= 1'b1;
                            end
                        end
                        dopc_pkg::OP_SAFE_V:
                        begin
                            if (safe_lv_reg[ch] != bitv)
                            begin
                                safe_lv_reg[ch] <= bitv;
                                upd_reg <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            if (cmd.lens)
            begin
                high_reg[ch] <= hi_fin;
                low_reg[ch] <= lo_fin;
                if ((mode_reg[ch] == dopc_pkg::MODE_PWM) && pwm_en_reg[ch] &&
                    (hi_fin != '0)) timer_reg <= 1'b1;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= cmd_word;
        end
        if (cmd.mul)
        begin
            total_reg <= 26'(period_reg[ch] * 26'd1000);
            prod_reg <= {15'd0, total_reg} * {26'd0, fill_reg[ch]};
        end
        if (cmd.div)
        begin
            q_est_reg <= q100_est;
        end
    end

    assign done = done_reg;
    assign result.updated = upd_reg;
    assign result.pins = pin_reg;
    assign result.timer_running = timer_reg;
    assign result.safe_allow_mask = safe_en_reg;
    assign result.safe_value_mask = safe_lv_reg;
endmodule
`default_nettype wire

// ----- rtl/core/discrete_output_pwm_channels_core.sv -----
// Top level: discrete output core with per-channel software PWM.
//
// channel  | signals                          | handshake
// command  | start, busy, cmd                 | taken when start && !busy
// config   | cfg_we, cfg_index, cfg_data      | written when cfg_we
// result   | done, result                     | one-cycle strobe, no stall
//
// A simple command or tick runs through the execute and result states,
// and done is registered from the result state; a fill or period command
// also runs through the two-step multiply of period, 1000 and fill, the
// reciprocal divide by 25600 and the length write-back. One word is in
// flight at a time, and busy covers the sequence.
// Reset is asynchronous active low and restores every control register.
// The receiver cannot stall: result holds for the cycle after done too.
`default_nettype none
module discrete_output_pwm_channels_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire dopc_pkg::in_word_t  cmd,
    input  wire logic                cfg_we,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [15:0]         cfg_data,
    output logic                     done,
    output dopc_pkg::out_word_t      result
);
    dopc_pkg::cmd_t  ctl;
    dopc_pkg::stat_t stat;

    // sequencing only; all channel state lives in the datapath
    dopc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .busy  (busy),
        .cmd   (ctl)
    );

    dopc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (ctl),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

    // a word taken always leads to busy next cycle
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("start not taken");
    // done only at the end of a word
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy)) else $error("done without work");
    // done is a single-cycle strobe
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than a cycle");
endmodule
`default_nettype wire
